/* sv/imh_pkg.sv */
package imh_pkg;

  localparam int OPW  = 3;
  localparam int HDW  = 11;
  localparam int VALW = 32;
  localparam int STW  = 2;
  localparam int CNTW = 11;

  localparam logic [OPW-1:0] OP_INSERT = 3'd0;
  localparam logic [OPW-1:0] OP_PEEK   = 3'd1;
  localparam logic [OPW-1:0] OP_DELMIN = 3'd2;
  localparam logic [OPW-1:0] OP_DELETE = 3'd3;
  localparam logic [OPW-1:0] OP_MODIFY = 3'd4;

  localparam logic [STW-1:0] ST_OK    = 2'd0;
  localparam logic [STW-1:0] ST_EMPTY = 2'd1;
  localparam logic [STW-1:0] ST_FULL  = 2'd2;
  localparam logic [STW-1:0] ST_STALE = 2'd3;

  typedef struct packed {
    logic [OPW-1:0]         opcode;
    logic [HDW-1:0]         handle;
    logic signed [VALW-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [VALW-1:0] min_value;
    logic [HDW-1:0]         assigned_handle;
    logic [STW-1:0]         status;
    logic [CNTW-1:0]        count;
  } rsp_t;

endpackage

/* sv/imh_if.sv */
interface imh_req_if import imh_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface imh_rsp_if import imh_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/imh_ram.sv */
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/indexed_min_heap_top.sv */
// peek and requests rejected at dispatch go straight to the result, a stale handle after
// the live-bit check; insert, delete-min, delete and modify sift the entry up, then down
// throughput: one item at a time; the sift loop over the slot memory sets the rate
// a finished result waits in the output register while the next item is taken
// reset (synchronous): count and handle counter cleared, no memory clearing pass;
// handles above the last issued one read as not live
module indexed_min_heap_top import imh_pkg::*; #(
  parameter int CAPACITY    = 1024,
  parameter int HANDLES     = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input logic clk,
  input logic rst,
  imh_req_if.sink   req,
  imh_rsp_if.source rsp
);

  localparam int SW  = $clog2(CAPACITY + 1);
  localparam int HW  = $clog2(HANDLES + 1);
  localparam int VW  = VALUE_WIDTH;
  localparam int HCW = ((HW > HDW) ? HW : HDW) + 1;
  localparam logic [VW-1:0] SIGN = {1'b1, {(VW - 1){1'b0}}};

  typedef enum logic [13:0] {
    IDLE = 14'b00000000000001,
    DISP = 14'b00000000000010,
    DM1  = 14'b00000000000100,
    LAST = 14'b00000000001000,
    HCHK = 14'b00000000010000,
    UP   = 14'b00000000100000,
    UPC  = 14'b00000001000000,
    DNL  = 14'b00000010000000,
    DNR  = 14'b00000100000000,
    DNC  = 14'b00001000000000,
    DNM  = 14'b00010000000000,
    FIN  = 14'b00100000000000,
    MRD  = 14'b01000000000000,
    MWT  = 14'b10000000000000
  } state_t;

  state_t state;

  logic [OPW-1:0] op;
  logic [HDW-1:0] hd;
  logic [VW-1:0]  key;
  logic [VW-1:0]  ev;
  logic [HW-1:0]  eh;
  logic [VW-1:0]  best_v;
  logic [HW-1:0]  best_h;
  logic [SW-1:0]  s;
  logic [SW-1:0]  t;
  logic [SW-1:0]  count;
  logic [HW-1:0]  nh;
  logic [STW-1:0] status;
  logic [HDW-1:0] assigned;

  logic           s_we;
  logic [SW-1:0]  s_waddr;
  logic [VW+HW-1:0] s_wdata;
  logic [SW-1:0]  s_raddr;
  logic [VW+HW-1:0] s_rdata;
  logic           h_we;
  logic [HW-1:0]  h_waddr;
  logic [SW-1:0]  h_wdata;
  logic [HW-1:0]  h_raddr;
  logic [SW-1:0]  h_rdata;
  logic           l_we;
  logic [HW-1:0]  l_waddr;
  logic [0:0]     l_wdata;
  logic [HW-1:0]  l_raddr;
  logic [0:0]     l_rdata;

  logic [VW-1:0]  s_rv;
  logic [HW-1:0]  s_rh;
  logic [HW-1:0]  hidx;
  logic [SW:0]    lchild;
  logic [SW:0]    rchild;
  logic [SW:0]    cnt_x;
  logic           full;
  logic           stale;

  assign s_rv   = s_rdata[VW-1:0];
  assign s_rh   = s_rdata[VW+HW-1:VW];
  assign hidx   = HW'(hd);
  assign lchild = {s, 1'b0};
  assign rchild = {s, 1'b1};
  assign cnt_x  = {1'b0, count};
  assign full   = (count >= SW'(CAPACITY)) || (nh >= HW'(HANDLES));
  assign stale  = (hd == '0) || (HCW'(hd) > HCW'(HANDLES)) || (HCW'(hd) > HCW'(nh));

  assign req.ready = (state == IDLE);

  imh_ram #(.WIDTH(VW + HW), .DEPTH(CAPACITY + 1)) u_slot (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  imh_ram #(.WIDTH(SW), .DEPTH(HANDLES + 1)) u_h2s (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  imh_ram #(.WIDTH(1), .DEPTH(HANDLES + 1)) u_live (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  always_comb begin
    s_we    = 1'b0;
    s_waddr = s;
    s_wdata = {eh, ev};
    s_raddr = '0;
    h_we    = 1'b0;
    h_waddr = eh;
    h_wdata = s;
    h_raddr = hidx;
    l_we    = 1'b0;
    l_waddr = hidx;
    l_wdata = 1'b0;
    l_raddr = hidx;
    case (state)
      DISP: begin
        if (op == OP_DELMIN) begin
          s_raddr = SW'(1);
        end
        if (op == OP_INSERT && !full) begin
          l_we    = 1'b1;
          l_waddr = nh + HW'(1);
          l_wdata = 1'b1;
        end
      end
      DM1: begin
        l_we    = 1'b1;
        l_waddr = s_rh;
        s_raddr = count;
      end
      HCHK: begin
        if (l_rdata[0] && op == OP_DELETE) begin
          l_we = 1'b1;
        end
        s_raddr = count;
      end
      UP: s_raddr = s >> 1;
      UPC: begin
        // parent larger: move it down into the hole
        if (s_rv > ev) begin
          s_we    = 1'b1;
          s_wdata = s_rdata;
          h_we    = 1'b1;
          h_waddr = s_rh;
        end
      end
      DNL: s_raddr = lchild[SW-1:0];
      DNR: s_raddr = rchild[SW-1:0];
      DNM: begin
        if (t != s) begin
          s_we    = 1'b1;
          s_wdata = {best_h, best_v};
          h_we    = 1'b1;
          h_waddr = best_h;
        end
      end
      FIN: begin
        s_we = 1'b1;
        h_we = 1'b1;
      end
      MRD: s_raddr = SW'(1);
      // keep the root on the read port while the result waits
      MWT: s_raddr = SW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      nh        <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != MWT) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (req.valid) begin
            op       <= req.data.opcode;
            hd       <= req.data.handle;
            key      <= VW'($unsigned(req.data.value)) ^ SIGN;
            status   <= ST_OK;
            assigned <= '0;
            state    <= DISP;
          end
        end
        DISP: begin
          case (op)
            OP_INSERT: begin
              if (full) begin
                status <= ST_FULL;
                state  <= MRD;
              end else begin
                count    <= count + SW'(1);
                nh       <= nh + HW'(1);
                assigned <= HDW'(nh + HW'(1));
                ev       <= key;
                eh       <= nh + HW'(1);
                s        <= count + SW'(1);
                state    <= UP;
              end
            end
            OP_PEEK: begin
              if (count == '0) begin
                status <= ST_EMPTY;
              end
              state <= MRD;
            end
            OP_DELMIN: begin
              if (count == '0) begin
                status <= ST_EMPTY;
                state  <= MRD;
              end else begin
                s     <= SW'(1);
                state <= DM1;
              end
            end
            OP_DELETE, OP_MODIFY: begin
              if (stale) begin
                status <= ST_STALE;
                state  <= MRD;
              end else begin
                state <= HCHK;
              end
            end
            default: state <= MRD;
          endcase
        end
        DM1: state <= LAST;
        LAST: begin
          // last entry fills the hole left by the removed one
          ev    <= s_rv;
          eh    <= s_rh;
          count <= count - SW'(1);
          if (s > count - SW'(1)) begin
            state <= MRD;
          end else begin
            state <= UP;
          end
        end
        HCHK: begin
          if (!l_rdata[0]) begin
            status <= ST_STALE;
            state  <= MRD;
          end else begin
            s <= h_rdata;
            if (op == OP_DELETE) begin
              state <= LAST;
            end else begin
              ev    <= key;
              eh    <= hidx;
              state <= UP;
            end
          end
        end
        UP: begin
          if (s == SW'(1)) begin
            state <= DNL;
          end else begin
            state <= UPC;
          end
        end
        UPC: begin
          if (s_rv > ev) begin
            s     <= s >> 1;
            state <= UP;
          end else begin
            state <= DNL;
          end
        end
        DNL: begin
          if (lchild > cnt_x) begin
            state <= FIN;
          end else begin
            state <= DNR;
          end
        end
        DNR: begin
          if (s_rv < ev) begin
            best_v <= s_rv;
            best_h <= s_rh;
            t      <= lchild[SW-1:0];
          end else begin
            best_v <= ev;
            best_h <= eh;
            t      <= s;
          end
          if (rchild <= cnt_x) begin
            state <= DNC;
          end else begin
            state <= DNM;
          end
        end
        DNC: begin
          // right child wins only when strictly smaller
          if (s_rv < best_v) begin
            best_v <= s_rv;
            best_h <= s_rh;
            t      <= rchild[SW-1:0];
          end
          state <= DNM;
        end
        DNM: begin
          if (t == s) begin
            state <= FIN;
          end else begin
            s     <= t;
            state <= DNL;
          end
        end
        FIN: state <= MRD;
        MRD: state <= MWT;
        MWT: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid                <= 1'b1;
            rsp.data.min_value       <= (count == '0) ? '0 : VALW'(s_rv ^ SIGN);
            rsp.data.assigned_handle <= assigned;
            rsp.data.status          <= status;
            rsp.data.count           <= CNTW'(count);
            state                    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

/* sv/imh_check.sv */
module imh_check import imh_pkg::*; (
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp_data
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result changed while stalled");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status == ST_EMPTY |-> rsp_data.count == '0)
    else $error("empty status with entries present");

  a_handle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status != ST_OK |-> rsp_data.assigned_handle == '0)
    else $error("handle given on rejected request");

  a_min: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.count == '0 |-> rsp_data.min_value == '0)
    else $error("nonzero minimum on empty heap");

endmodule

bind indexed_min_heap_top imh_check u_imh_check (
  .clk(clk),
  .rst(rst),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .rsp_data(rsp.data)
);
